### rtl/keyed_list_store_with_compaction_top_macros.svh
// Assertion macros for the keyed list store.
// Included by the top level; depends on nothing else.
`ifndef KEYED_LIST_STORE_WITH_COMPACTION_TOP_MACROS_SVH
`define KEYED_LIST_STORE_WITH_COMPACTION_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KLSC_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("klsc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KLSC_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("klsc assertion failed");

`endif

### rtl/klsc_pkg.sv
// Shared types and constants of the keyed list store.
// Used by the storage cell and the top level; depends on nothing.
`default_nettype none

package klsc_pkg;

  localparam int KLSC_DEPTH       = 64;
  localparam int KLSC_ENTRY_WIDTH = 32;

  // Fixed widths of the register and transaction fields.
  localparam int CAP_W    = 7;
  localparam int WORD_W   = 32;
  localparam int OCOUNT_W = 7;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 7'd64;
  localparam logic [WORD_W-1:0] MASK_RESET = 32'hFFFF_FFFF;

  // Register index, taken from paddr[2].
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_MASK     = 1'b1;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  // Per-cycle controls broadcast to every cell.
  typedef struct packed {
    logic capture;  // register the masked compare of every cell
    logic insert;   // the cell at the fill position takes the key
    logic remove;   // cells at or above the first hit take their upper neighbor
  } cell_ctl_t;

endpackage

`default_nettype wire

### rtl/klsc_cell.sv
// One storage cell of the list: an entry word, its match flag and its link
// in the first-hit chain. Depends on klsc_pkg.
`default_nettype none

module klsc_cell import klsc_pkg::*; #(
  parameter int EW    = KLSC_ENTRY_WIDTH,
  parameter int CW    = 7,
  parameter int INDEX = 0
) (
  input  wire logic            clk,
  input  wire cell_ctl_t       ctl,
  input  wire logic [CW-1:0]   count,
  input  wire logic [EW-1:0]   key,
  input  wire logic [EW-1:0]   mask,
  input  wire logic [EW-1:0]   up_data,
  input  wire logic            hit_in,
  input  wire logic [EW-1:0]   sel_in,
  output logic                 hit_out,
  output logic [EW-1:0]        sel_out,
  output logic [EW-1:0]        data_out
);

  localparam logic [CW-1:0] MY_INDEX = CW'(INDEX);

  logic [EW-1:0] data_r, data_nxt;
  logic          match_r;
  logic          valid;

  // Only positions below the fill count hold written entries.
  assign valid = MY_INDEX < count;

  // The first cell that matches drives the found word; cells above pass it on.
  assign hit_out  = hit_in | match_r;
  assign sel_out  = hit_in ? sel_in : (match_r ? data_r : '0);
  assign data_out = data_r;

  always_comb begin
    data_nxt = data_r;
    if (ctl.insert && (MY_INDEX == count)) begin
      data_nxt = key;
    end else if (ctl.remove && hit_out) begin
      data_nxt = up_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (ctl.capture) begin
      match_r <= valid && (((data_r ^ key) & mask) == '0);
    end
  end

endmodule

`default_nettype wire

### rtl/keyed_list_store_with_compaction_top.sv
// Top level of the keyed list store: configuration registers, command
// sequencer and the row of storage cells. Depends on klsc_pkg, klsc_cell
// and the assertion macro header.
//
// At the accepting edge every cell registers its masked compare against
// the key; busy is then high for one cycle, during which the first-hit
// chain through the cells resolves the lowest matching entry, a remove
// shifts the entries above it down one place and an insert writes the
// cell at the fill position. The result is shown on out_status, out_entry
// and out_count for exactly one cycle, marked by out_valid, in the cycle
// after busy; it cannot be held off, so the receiver must take it then.
// A new start is accepted in that same cycle; none is taken while busy.
// The first-hit chain runs through all DEPTH cells and sets the length of
// the busy cycle's path.
// Entry contents are undefined after reset and need no clearing pass;
// only the fill count is cleared.
`default_nettype none

`include "keyed_list_store_with_compaction_top_macros.svh"

module keyed_list_store_with_compaction_top import klsc_pkg::*; #(
  parameter int DEPTH       = KLSC_DEPTH,
  parameter int ENTRY_WIDTH = KLSC_ENTRY_WIDTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // command channel
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          in_cmd,
  input  wire logic [WORD_W-1:0]   in_key,
  // result channel
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output logic [WORD_W-1:0]        out_entry,
  output logic [OCOUNT_W-1:0]      out_count,
  // configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [WORD_W-1:0]   pwdata,
  output logic [WORD_W-1:0]        prdata,
  output logic                     pready
);

  localparam int EW = ENTRY_WIDTH;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  // ---------------------------------------------------------------- config
  logic [CAP_W-1:0]  capacity_r;
  logic [WORD_W-1:0] mask_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_MASK) ? mask_r : WORD_W'(capacity_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
      mask_r     <= MASK_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_CAPACITY: capacity_r <= pwdata[CAP_W-1:0];
        REG_MASK:     mask_r     <= pwdata;
        default:      ;
      endcase
    end
  end

  // ------------------------------------------------------------- sequencer
  state_t            state_r, state_nxt;
  cmd_t              cmd_r;
  logic [EW-1:0]     key_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic              out_valid_r;
  status_t           status_r, status_nxt;
  logic [WORD_W-1:0] entry_r, entry_nxt;

  logic              accept;
  logic [63:0]       key_wide, mask_wide, found_wide;
  logic [EW-1:0]     in_key_ew, mask_ew, cell_key;
  logic [LW-1:0]     limit;
  logic              room;
  logic              found;
  logic [EW-1:0]     found_data;
  cell_ctl_t         ctl;

  assign busy   = (state_r == S_EXEC);
  assign accept = start && !busy;

  // Keys and masks are stored and compared in their low EW bits.
  assign key_wide  = 64'(in_key);
  assign mask_wide = 64'(mask_r);
  assign in_key_ew = key_wide[EW-1:0];
  assign mask_ew   = mask_wide[EW-1:0];
  assign cell_key  = busy ? key_r : in_key_ew;

  assign limit = (LW'(capacity_r) > DEPTH_L) ? DEPTH_L : LW'(capacity_r);
  assign room  = LW'(count_r) < limit;

  always_comb begin
    ctl         = '0;
    ctl.capture = accept;
    state_nxt   = state_r;
    count_nxt   = count_r;
    status_nxt  = ST_MISS;
    entry_nxt   = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        case (cmd_r)
          CMD_INSERT: begin
            if (room) begin
              ctl.insert = 1'b1;
              count_nxt  = count_r + 1'b1;
              status_nxt = ST_DONE;
            end else begin
              status_nxt = ST_FULL;
            end
          end
          CMD_SEARCH, CMD_REMOVE: begin
            if (found) begin
              status_nxt = ST_DONE;
              entry_nxt  = found_wide[WORD_W-1:0];
              if (cmd_r == CMD_REMOVE) begin
                ctl.remove = 1'b1;
                count_nxt  = count_r - 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The found word is widened so that it can be cut to the result width.
  always_comb begin
    found_wide = 64'(found_data);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= busy;
    end
    if (accept) begin
      cmd_r <= cmd_t'(in_cmd);
      key_r <= in_key_ew;
    end
    if (busy) begin
      status_r <= status_nxt;
      entry_r  <= entry_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_entry  = entry_r;
  assign out_count  = OCOUNT_W'(count_r);

  // ----------------------------------------------------------- cell row
  logic          hit  [DEPTH+1];
  logic [EW-1:0] sel  [DEPTH+1];
  logic [EW-1:0] data [DEPTH];

  assign hit[0] = 1'b0;
  assign sel[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [EW-1:0] up;
    if (i == DEPTH - 1) begin : g_last
      assign up = data[i];
    end else begin : g_mid
      assign up = data[i+1];
    end

    klsc_cell #(
      .EW    (EW),
      .CW    (CW),
      .INDEX (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .count    (count_r),
      .key      (cell_key),
      .mask     (mask_ew),
      .up_data  (up),
      .hit_in   (hit[i]),
      .sel_in   (sel[i]),
      .hit_out  (hit[i+1]),
      .sel_out  (sel[i+1]),
      .data_out (data[i])
    );
  end

  assign found      = hit[DEPTH];
  assign found_data = sel[DEPTH];

  // ------------------------------------------------------------ assertions
  `KLSC_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, busy)
  `KLSC_ASSERT_NXT(a_exec_result, clk, rst_n, busy, out_valid && !busy)
  `KLSC_ASSERT_IMP(a_full_no_entry, clk, rst_n,
                   out_valid && (out_status == ST_FULL), out_entry == '0)
  `KLSC_ASSERT_NXT(a_miss_keeps_count, clk, rst_n,
                   busy && (status_nxt != ST_DONE), count_r == $past(count_r))

endmodule

`default_nettype wire
